/* src/gbp_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and counter arithmetic for the gshare branch predictor.
// Depends on nothing; every other file imports it.
package gbp_pkg;

  typedef logic [1:0] ctr_t;

  typedef enum logic {
    OP_PREDICT = 1'b0,
    OP_TRAIN   = 1'b1
  } op_t;

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } clr_state_t;

  localparam ctr_t CTR_MAX  = 2'd3;
  localparam ctr_t CTR_MIN  = 2'd0;
  localparam ctr_t CTR_STEP = 2'd1;

  localparam int ADDR_W   = 32;
  localparam int S_DATA_W = 40;
  localparam int M_DATA_W = 8;

  function automatic ctr_t ctr_update(input ctr_t ctr, input logic taken);
    ctr_t res;
    res = ctr;
    if (taken) begin
      if (ctr != CTR_MAX) res = ctr + CTR_STEP;
    end else begin
      if (ctr != CTR_MIN) res = ctr - CTR_STEP;
    end
    return res;
  endfunction

endpackage

/* src/gshare_branch_predictor.sv */
`timescale 1ns / 1ps
// Top level of the gshare branch predictor: history, lookup stage and result register.
// Depends on gbp_pkg, gbp_counter_ram and gbp_clear_seq.
//
//   Channel | Direction | Content
//   s_*     | in        | tdata: branch_address, actual_taken; tuser: opcode
//   m_*     | out       | tdata: predict_taken
//
// One request per cycle is taken while s_tready is high; the result register feeds m_*.
// The counter memory has one read port with registered data, and a write to the entry
// read by the following request is forwarded from a register.
// After reset a clearing pass zeroes all 2**HISTORY_BITS table entries; s_tready is low.
// A stalled result holds the lookup stage, and s_tready drops until it moves.
module gshare_branch_predictor #(
  parameter int HISTORY_BITS = 12
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // Bits from low: branch_address[31:0], actual_taken[32], zero fill.
  input  logic [gbp_pkg::S_DATA_W-1:0]  s_tdata,
  // Bits from low: opcode[0].
  input  logic                          s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // Bits from low: predict_taken[0], zero fill.
  output logic [gbp_pkg::M_DATA_W-1:0]  m_tdata
);
  import gbp_pkg::*;

  localparam int H = HISTORY_BITS;

  logic [H-1:0] history;
  logic [H:0]   history_shift;
  logic [H-1:0] in_idx;
  logic         in_taken;
  logic         accept;

  logic         s1_valid;
  logic [H-1:0] s1_idx;
  op_t          s1_op;
  logic         s1_taken;
  logic         s1_adv;

  logic         fwd_valid;
  logic [H-1:0] fwd_idx;
  ctr_t         fwd_ctr;

  ctr_t         rd_data;
  ctr_t         ctr_cur;
  ctr_t         ctr_new;
  logic [H-1:0] rd_addr;
  logic         wr_en;
  logic [H-1:0] wr_addr;
  ctr_t         wr_data;
  logic         train_wr;

  logic         clr_busy;
  logic         clr_we;
  logic [H-1:0] clr_addr;

  logic         pred;

  assign in_idx        = history ^ s_tdata[H-1:0];
  assign in_taken      = s_tdata[ADDR_W];
  assign accept        = s_tvalid & s_tready;
  assign s1_adv        = s1_valid & (~m_tvalid | m_tready);
  assign s_tready      = ~clr_busy & (~s1_valid | s1_adv);
  assign rd_addr       = accept ? in_idx : s1_idx;
  assign history_shift = {history, in_taken};

  assign ctr_cur  = (fwd_valid && fwd_idx == s1_idx) ? fwd_ctr : rd_data;
  assign ctr_new  = ctr_update(ctr_cur, s1_taken);
  assign train_wr = s1_adv & (s1_op == OP_TRAIN);
  assign wr_en    = clr_we | train_wr;
  assign wr_addr  = clr_busy ? clr_addr : s1_idx;
  assign wr_data  = clr_busy ? CTR_MIN : ctr_new;

  assign m_tdata  = {{(M_DATA_W - 1){1'b0}}, pred};

  gbp_clear_seq #(.IDX_W(H)) u_clear (
    .clk  (clk),
    .rst  (rst),
    .busy (clr_busy),
    .we   (clr_we),
    .addr (clr_addr)
  );

  gbp_counter_ram #(.IDX_W(H)) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      history   <= '0;
      s1_valid  <= 1'b0;
      fwd_valid <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (accept && op_t'(s_tuser) == OP_TRAIN) begin
        history <= history_shift[H-1:0];
      end
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (train_wr) begin
        fwd_valid <= 1'b1;
      end
      if (s1_adv) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_idx   <= in_idx;
      s1_op    <= op_t'(s_tuser);
      s1_taken <= in_taken;
    end
    if (train_wr) begin
      fwd_idx <= s1_idx;
      fwd_ctr <= ctr_new;
    end
    if (s1_adv) begin
      pred <= ctr_cur[1];
    end
  end

endmodule

/* src/gbp_counter_ram.sv */
`timescale 1ns / 1ps
// Pattern counter table: one write port and one read port with registered data.
// Depends on gbp_pkg for the counter type.
module gbp_counter_ram #(
  parameter int IDX_W = 12
) (
  input  logic               clk,
  input  logic               we,
  input  logic [IDX_W-1:0]   waddr,
  input  gbp_pkg::ctr_t      wdata,
  input  logic [IDX_W-1:0]   raddr,
  output gbp_pkg::ctr_t      rdata
);
  import gbp_pkg::*;

  localparam int DEPTH = 1 << IDX_W;

  ctr_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* src/gbp_clear_seq.sv */
`timescale 1ns / 1ps
// Clearing sequencer that zeroes every counter entry after reset.
// Depends on gbp_pkg for the state type.
module gbp_clear_seq #(
  parameter int IDX_W = 12
) (
  input  logic             clk,
  input  logic             rst,
  output logic             busy,
  output logic             we,
  output logic [IDX_W-1:0] addr
);
  import gbp_pkg::*;

  clr_state_t state;
  clr_state_t state_next;
  logic [IDX_W-1:0] addr_next;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (addr == {IDX_W{1'b1}}) state_next = ST_RUN;
      end
      ST_RUN: begin
        state_next = ST_RUN;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    busy      = 1'b0;
    we        = 1'b0;
    addr_next = addr;
    unique case (state)
      ST_CLEAR: begin
        busy      = 1'b1;
        we        = 1'b1;
        addr_next = addr + 1'b1;
      end
      ST_RUN: begin
        busy = 1'b0;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      addr  <= '0;
    end else begin
      state <= state_next;
      addr  <= addr_next;
    end
  end

endmodule

/* tb/gshare_branch_predictor_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for gshare_branch_predictor: a scoreboard class predicts each
// result from its own history and counter table; tasks drive s_*, a process drives m_tready.
// Depends on gbp_pkg and the gshare_branch_predictor RTL.
module gshare_branch_predictor_tb;
  import gbp_pkg::*;

  localparam int HIST_W       = 12;
  localparam int TABLE_DEPTH  = 1 << HIST_W;
  localparam int RANDOM_ITEMS = 2000;
  localparam int HOLD_AT      = 500;
  localparam int HOLD_CYCLES  = 200;
  localparam int TAIL_CYCLES  = 20;
  localparam int POOL_SIZE    = 8;

  class gshare_scoreboard;
    logic [HIST_W-1:0] history;
    ctr_t              counters [TABLE_DEPTH];
    logic              taken_q [$];
    int                mismatches;

    function new();
      history    = '0;
      mismatches = 0;
      foreach (counters[i]) counters[i] = CTR_MIN;
    endfunction

    function void note_request(op_t op, logic [ADDR_W-1:0] addr, logic taken);
      logic [HIST_W-1:0] idx;
      ctr_t              ctr;
      idx = history ^ addr[HIST_W-1:0];
      ctr = counters[idx];
      taken_q.push_back(ctr >= 2'd2);
      if (op == OP_TRAIN) begin
        if (taken) begin
          if (ctr != CTR_MAX) ctr = ctr + 2'd1;
        end else begin
          if (ctr != CTR_MIN) ctr = ctr - 2'd1;
        end
        counters[idx] = ctr;
        history = {history[HIST_W-2:0], taken};
      end
    endfunction

    function void check_result(logic [M_DATA_W-1:0] data);
      logic want;
      if (taken_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result: m_tdata=%h", data);
      end else begin
        want = taken_q.pop_front();
        if (data !== {{(M_DATA_W-1){1'b0}}, want}) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Prediction mismatch: expected %h, got %h",
                     {{(M_DATA_W-1){1'b0}}, want}, data);
        end
      end
    endfunction

    function int outstanding();
      return taken_q.size();
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata;
  logic                s_tuser;
  logic                m_tvalid;
  logic                m_tready;
  logic [M_DATA_W-1:0] m_tdata;

  gshare_scoreboard sb = new();
  int               results_seen;
  logic [ADDR_W-1:0] addr_pool [POOL_SIZE];
  int                bias_pool [POOL_SIZE];

  gshare_branch_predictor #(
    .HISTORY_BITS(HIST_W)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #2 clk = ~clk;

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Offers one request and returns at its accepting edge, or after a random idle gap
  // allowed by allow_gap; inputs sampled at negedge hold what the next posedge sees.
  task automatic send_request(op_t op, logic [ADDR_W-1:0] addr, logic taken, bit allow_gap);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {{(S_DATA_W-ADDR_W-1){1'b0}}, taken, addr};
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
    sb.note_request(op, addr, taken);
    if (allow_gap && $urandom_range(99) < 15) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Aims a request at one table entry under the current history, with random upper bits.
  task automatic hit_entry(op_t op, logic [HIST_W-1:0] entry, logic taken);
    logic [ADDR_W-1:0] addr;
    addr = $urandom();
    addr[HIST_W-1:0] = sb.history ^ entry;
    send_request(op, addr, taken, 1'b1);
  endtask

  task automatic send_random(bit allow_gap);
    int                k;
    op_t               op;
    logic [ADDR_W-1:0] addr;
    logic              taken;
    if ($urandom_range(99) < 20) begin
      op    = op_t'($urandom_range(1));
      addr  = $urandom();
      taken = 1'($urandom_range(1));
    end else begin
      k     = $urandom_range(POOL_SIZE - 1);
      op    = ($urandom_range(99) < 70) ? OP_TRAIN : OP_PREDICT;
      addr  = addr_pool[k];
      taken = ($urandom_range(99) < bias_pool[k]);
    end
    send_request(op, addr, taken, allow_gap);
  endtask

  task automatic wait_drained();
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  // Result side: random stalls, one long hold-off and one stretch that never stalls.
  initial begin
    int hold_left;
    bit hold_done;
    hold_left    = 0;
    hold_done    = 1'b0;
    results_seen = 0;
    m_tready     = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else if (!hold_done && results_seen >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        m_tready <= 1'b0;
      end else if (results_seen >= 1300 && results_seen < 1600) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(99) >= 15);
      end
      @(negedge clk);
      if (m_tvalid === 1'b1 && m_tready) begin
        sb.check_result(m_tdata);
        results_seen++;
      end
    end
  end

  initial begin
    clk      = 1'b0;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = OP_PREDICT;
    foreach (addr_pool[i]) begin
      addr_pool[i] = $urandom();
      bias_pool[i] = (i % 5 == 0) ? 0 : (i % 5 == 1) ? 100 :
                     (i % 5 == 2) ? 90 : (i % 5 == 3) ? 10 : 50;
    end
    addr_pool[POOL_SIZE-1] = 32'hFFFF_FFFF;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: fresh table, saturation at both ends, ignored outcome on predict,
    // address extremes, and enough trains to push old history bits off the top.
    send_request(OP_PREDICT, 32'h0000_0000, 1'b1, 1'b1);
    send_request(OP_PREDICT, 32'hFFFF_FFFF, 1'b0, 1'b1);
    repeat (4) hit_entry(OP_TRAIN, 12'h000, 1'b1);
    hit_entry(OP_PREDICT, 12'h000, 1'b0);
    repeat (4) hit_entry(OP_TRAIN, 12'h000, 1'b0);
    hit_entry(OP_PREDICT, 12'h000, 1'b1);
    repeat (2) hit_entry(OP_TRAIN, 12'hFFF, 1'b1);
    hit_entry(OP_PREDICT, 12'hFFF, 1'b0);
    hit_entry(OP_TRAIN, 12'hFFF, 1'b1);
    hit_entry(OP_TRAIN, 12'hFFF, 1'b1);
    hit_entry(OP_PREDICT, 12'hFFF, 1'b1);
    send_request(OP_TRAIN, 32'hFFFF_FFFF, 1'b1, 1'b0);
    send_request(OP_TRAIN, 32'h0000_0000, 1'b0, 1'b0);
    send_request(OP_PREDICT, 32'hFFFF_F000, 1'b1, 1'b1);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 1000) begin
        s_tvalid <= 1'b0;
        wait_drained();
      end
      send_random(!(n >= 1200 && n < 1500));
    end
    s_tvalid <= 1'b0;

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
